// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the ranked candidate list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TKD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkd assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TKD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkd assertion failed");

`else

`define TKD_ASSERT_IMPL(lbl, ante, cons)
`define TKD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/tkd_pkg.sv =====
// Package with sizes, operation codes and shared types of the ranked candidate list.
`timescale 1ns / 1ps

package tkd_pkg;

    // List depth, the widths that follow from it, and a fixed list-size width.
    localparam int LIST_SLOTS = 16;
    localparam int CNT_W      = $clog2(LIST_SLOTS + 1);
    localparam int IDX_W      = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
    localparam int SIZE_W     = 5;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    // One list entry.
    typedef struct packed {
        logic [31:0] answer_id;
        logic [15:0] question_length;
        logic [7:0]  keyword_count;
        logic [31:0] handle;
    } entry_t;

    // One request as captured by the datapath.
    typedef struct packed {
        logic [1:0] kind;
        entry_t     entry;
    } item_t;

    // One result as held in the output register.
    typedef struct packed {
        logic              accepted;
        logic              duplicate;
        logic              has_entry;
        entry_t            entry;
        logic [SIZE_W-1:0] list_size;
        logic              last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fin_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ===== sv/tkd_req_if.sv =====
// Request channel: valid/ready handshake with the candidate fields.
`timescale 1ns / 1ps

interface tkd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] answer_id;
    logic [15:0] question_length;
    logic [7:0]  keyword_count;
    logic [31:0] entry_handle;

    modport source
    (
        output valid, kind, answer_id, question_length, keyword_count, entry_handle,
        input  ready
    );

    modport sink
    (
        input  valid, kind, answer_id, question_length, keyword_count, entry_handle,
        output ready
    );
endinterface

// ===== sv/tkd_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface tkd_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        duplicate;
    logic        has_entry;
    logic [31:0] out_answer_id;
    logic [15:0] out_question_length;
    logic [7:0]  out_keyword_count;
    logic [31:0] out_handle;
    logic [4:0]  list_size;
    logic        last;

    modport source
    (
        output valid, accepted, duplicate, has_entry, out_answer_id,
               out_question_length, out_keyword_count, out_handle, list_size, last,
        input  ready
    );

    modport sink
    (
        input  valid, accepted, duplicate, has_entry, out_answer_id,
               out_question_length, out_keyword_count, out_handle, list_size, last,
        output ready
    );
endinterface

// ===== sv/tkd_ctrl.sv =====
// Controller state machine: takes requests and sequences result transfers.
`timescale 1ns / 1ps

module tkd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tkd_pkg::ctrl_stat_t    stat,
    output tkd_pkg::ctrl_cmd_t     cmd
);
    import tkd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    logic state_reg;
    logic state_next;

    // Requests are taken only in idle; finishing waits for a free output register.
    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    if (stat.fin_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== sv/tkd_datapath.sv =====
// Datapath: slot registers, parallel rank and duplicate compare, shift update, output register.
`timescale 1ns / 1ps

module tkd_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tkd_pkg::item_t         item,
    input  tkd_pkg::ctrl_cmd_t     cmd,
    input  logic                   out_ready,
    output tkd_pkg::ctrl_stat_t    stat,
    output logic                   out_valid,
    output tkd_pkg::result_t       result
);
    import tkd_pkg::*;

    item_t                 item_reg;
    logic                  dup_reg;
    logic [LIST_SLOTS-1:0] ge_reg;
    entry_t                slot_reg  [LIST_SLOTS];
    entry_t                slot_next [LIST_SLOTS];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               result_reg;
    result_t               result_next;

    logic [LIST_SLOTS-1:0] dup_hit;
    logic [LIST_SLOTS-1:0] ge_hit;
    logic [LIST_SLOTS-1:0] ge_lo;
    logic [LIST_SLOTS-1:0] ge_hi;
    entry_t                slot_dn [LIST_SLOTS];
    entry_t                slot_up [LIST_SLOTS];

    logic is_ins;
    logic is_clr;
    logic is_dump;
    logic full;
    logic do_place;
    logic do_replace;
    logic reject;
    logic has_dump;
    logic dump_end;

    // Compare the incoming candidate against every held slot at once.
    always_comb
    begin
        for (int i = 0; i < LIST_SLOTS; i++)
        begin
            logic in_use;
            logic below;
            in_use = (i < int'(count_reg));
            below  = (item.entry.question_length < slot_reg[i].question_length) ||
                     ((item.entry.question_length == slot_reg[i].question_length) &&
                      (item.entry.keyword_count > slot_reg[i].keyword_count));
            dup_hit[i] = in_use && (item.entry.answer_id == slot_reg[i].answer_id);
            ge_hit[i]  = in_use && !below;
        end
    end

    // Neighbor views of the slots and compare flags for the shift network.
    genvar g;
    generate
        for (g = 0; g < LIST_SLOTS; g++)
        begin : g_nbr
            if (g == 0)
            begin : g_first
                assign slot_dn[g] = slot_reg[g];
                assign ge_lo[g]   = 1'b1;
            end
            else
            begin : g_inner_lo
                assign slot_dn[g] = slot_reg[g-1];
                assign ge_lo[g]   = ge_reg[g-1];
            end
            if (g == LIST_SLOTS - 1)
            begin : g_last
                assign slot_up[g] = slot_reg[g];
                assign ge_hi[g]   = 1'b0;
            end
            else
            begin : g_inner_hi
                assign slot_up[g] = slot_reg[g+1];
                assign ge_hi[g]   = ge_reg[g+1];
            end
        end
    endgenerate

    // Decode of the captured request.
    assign is_ins     = (item_reg.kind == KIND_INSERT);
    assign is_clr     = (item_reg.kind == KIND_CLEAR);
    assign is_dump    = (item_reg.kind == KIND_DUMP);
    assign full       = (count_reg == CNT_W'(LIST_SLOTS));
    assign do_place   = is_ins && !dup_reg && !full;
    assign do_replace = is_ins && !dup_reg && full && ge_reg[0];
    assign reject     = is_ins && !dup_reg && full && !ge_reg[0];
    assign has_dump   = is_dump && (count_reg != '0);
    assign dump_end   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign stat.fin_last = !(has_dump && !dump_end);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Slot update: insert in rank order, or drop the minimum and insert.
    // The compare flags form a thermometer code, so the insert point is where it ends.
    always_comb
    begin
        for (int j = 0; j < LIST_SLOTS; j++)
        begin
            slot_next[j] = slot_reg[j];
            if (cmd.finish && do_place)
            begin
                if (ge_reg[j])
                begin
                    slot_next[j] = slot_reg[j];
                end
                else if (ge_lo[j])
                begin
                    slot_next[j] = item_reg.entry;
                end
                else
                begin
                    slot_next[j] = slot_dn[j];
                end
            end
            else if (cmd.finish && do_replace)
            begin
                if (ge_hi[j])
                begin
                    slot_next[j] = slot_up[j];
                end
                else if (ge_reg[j])
                begin
                    slot_next[j] = item_reg.entry;
                end
                else
                begin
                    slot_next[j] = slot_reg[j];
                end
            end
        end
    end

    // Fill count and read-out index.
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        if (cmd.finish)
        begin
            if (is_clr)
            begin
                count_next = '0;
            end
            else if (do_place)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (has_dump)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // Result assembly and output register handshake.
    always_comb
    begin
        result_next           = '0;
        result_next.list_size = SIZE_W'(count_next);
        result_next.last      = 1'b1;
        case (item_reg.kind)
            KIND_INSERT:
            begin
                result_next.accepted  = !reject;
                result_next.duplicate = dup_reg;
            end
            KIND_DUMP:
            begin
                if (has_dump)
                begin
                    result_next.has_entry = 1'b1;
                    result_next.entry     = slot_reg[idx_reg];
                    result_next.last      = dump_end;
                end
            end
            default:
            begin
                result_next.last = 1'b1;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: request capture, compare flags, slots and result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            dup_reg  <= |dup_hit;
            ge_reg   <= ge_hit;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
        for (int k = 0; k < LIST_SLOTS; k++)
        begin
            slot_reg[k] <= slot_next[k];
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
endmodule

// ===== sv/top_k_dedup_ranked_list.sv =====
// Top level of the ranked candidate list with duplicate filter.
//
// The req channel carries one operation per transfer: insert a candidate,
// clear the list, or dump the list in rank order (shortest question first,
// more keywords first on equal length, insertion order on equal keys).
// The rsp channel returns the results: one for insert, clear and unused
// codes, one per held entry for a dump (one result if the list is empty);
// last marks the final result of an operation.
// An insert or clear is compared against all 16 slots in parallel as it is
// taken, with the compare flags registered; once the output register is free,
// the slots shift and the result is written to the output register.
// A dump loads one result per held entry, one per cycle while the output
// register is free, and keeps the block busy until the last one is loaded.
// A new request is taken in the cycle after the last result of the
// previous one is loaded; no new request is taken while one is in progress.
// Reset empties the list; slot contents are not cleared.
// When the receiver stalls, the result holds in the output register and the
// block waits before loading the next one; a request may still be taken
// while a finished result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module top_k_dedup_ranked_list
(
    input  logic      clk,
    input  logic      rst_n,
    tkd_req_if.sink   req,
    tkd_rsp_if.source rsp
);
    import tkd_pkg::*;

    item_t      item;
    result_t    result;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       out_valid;

    // Request fields into the capture struct.
    assign item.kind                  = req.kind;
    assign item.entry.answer_id       = req.answer_id;
    assign item.entry.question_length = req.question_length;
    assign item.entry.keyword_count   = req.keyword_count;
    assign item.entry.handle          = req.entry_handle;

    tkd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tkd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .out_ready (rsp.ready),
        .stat      (stat),
        .out_valid (out_valid),
        .result    (result)
    );

    // Output register onto the result channel.
    assign rsp.valid               = out_valid;
    assign rsp.accepted            = result.accepted;
    assign rsp.duplicate           = result.duplicate;
    assign rsp.has_entry           = result.has_entry;
    assign rsp.out_answer_id       = result.entry.answer_id;
    assign rsp.out_question_length = result.entry.question_length;
    assign rsp.out_keyword_count   = result.entry.keyword_count;
    assign rsp.out_handle          = result.entry.handle;
    assign rsp.list_size           = result.list_size;
    assign rsp.last                = result.last;

    // A taken request keeps the block busy for at least the next cycle.
    `TKD_ASSERT_NEXT(a_busy_after_take, req.valid && req.ready, !req.ready)
    // Capturing a request and finishing one never coincide.
    `TKD_ASSERT_IMPL(a_load_excl_finish, cmd.load, !cmd.finish)
    // A dumped entry comes from a non-empty list and carries no insert flags.
    `TKD_ASSERT_IMPL(a_dump_entry, rsp.valid && rsp.has_entry,
                     (rsp.list_size != 5'd0) && !rsp.accepted && !rsp.duplicate)
endmodule

// ===== tb/top_k_dedup_ranked_list_test.sv =====
// Self-checking testbench of the ranked candidate list with its duplicate filter.
`timescale 1ns / 1ps

module top_k_dedup_ranked_list_test;
    import tkd_pkg::*;

    localparam int         RESET_CYCLES  = 11;
    localparam int         RANDOM_ITEMS  = 150;
    localparam int         IDLE_PERCENT  = 28;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    tkd_req_if req ();
    tkd_rsp_if rsp ();

    top_k_dedup_ranked_list i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Pending operations, the results they must produce, and the model of the list.
    item_t       pending_ops[$];
    result_t     expected_results[$];
    entry_t      held_entries[LIST_SLOTS];
    int          held_total;
    item_t       driven_op;
    result_t     seen_result;
    result_t     due_result;
    logic [31:0] used_ids[$];
    bit          calm_phase;
    int          queued_count;
    int          error_count;
    int          checked_count;
    int          cycle_count;
    int          insert_count;
    int          duplicate_count;
    int          reject_count;
    int          replace_count;
    int          dump_count;

    // Free-running clock with a 4 ns period.
    always #2 clk = ~clk;

    // Returns -1 when the candidate ranks below the held entry, 0 on equal keys, 1 above.
    function automatic int rank_against(entry_t cand, entry_t held);
        if (cand.question_length < held.question_length)
            return -1;
        if (cand.question_length > held.question_length)
            return 1;
        if (cand.keyword_count > held.keyword_count)
            return -1;
        if (cand.keyword_count < held.keyword_count)
            return 1;
        return 0;
    endfunction

    // Places a candidate after every entry that it does not rank below.
    task automatic place_in_rank(entry_t cand);
        int pos;
        pos = 0;
        while (pos < held_total && rank_against(cand, held_entries[pos]) >= 0)
            pos++;
        for (int j = held_total; j > pos; j--)
            held_entries[j] = held_entries[j - 1];
        held_entries[pos] = cand;
        held_total++;
    endtask

    // Updates the list model for one accepted operation and queues its results.
    task automatic predict_list_op(item_t op);
        result_t r;
        bit      dup;
        r = '0;
        if (op.kind == KIND_DUMP && held_total > 0)
        begin
            dump_count++;
            for (int i = 0; i < held_total; i++)
            begin
                r           = '0;
                r.has_entry = 1'b1;
                r.entry     = held_entries[i];
                r.list_size = SIZE_W'(held_total);
                r.last      = (i == held_total - 1);
                expected_results.push_back(r);
            end
        end
        else
        begin
            if (op.kind == KIND_INSERT)
            begin
                insert_count++;
                dup = 1'b0;
                for (int i = 0; i < held_total; i++)
                    if (held_entries[i].answer_id == op.entry.answer_id)
                        dup = 1'b1;
                r.accepted  = 1'b1;
                r.duplicate = dup;
                if (dup)
                    duplicate_count++;
                else if (held_total < LIST_SLOTS)
                    place_in_rank(op.entry);
                else if (rank_against(op.entry, held_entries[0]) < 0)
                begin
                    r.accepted = 1'b0;
                    reject_count++;
                end
                else
                begin
                    // Drop the minimum, then place the newcomer in rank order.
                    for (int j = 1; j < held_total; j++)
                        held_entries[j - 1] = held_entries[j];
                    held_total--;
                    place_in_rank(op.entry);
                    replace_count++;
                end
            end
            else if (op.kind == KIND_CLEAR)
                held_total = 0;
            else if (op.kind == KIND_DUMP)
                dump_count++;
            r.list_size = SIZE_W'(held_total);
            r.last      = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // Reports one field that differs from its expectation.
    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endfunction

    task automatic queue_op(logic [1:0] kind, logic [31:0] aid, logic [15:0] qlen,
                            logic [7:0] kw, logic [31:0] handle);
        item_t op;
        op.kind                  = kind;
        op.entry.answer_id       = aid;
        op.entry.question_length = qlen;
        op.entry.keyword_count   = kw;
        op.entry.handle          = handle;
        pending_ops.push_back(op);
        queued_count++;
    endtask

    // Holds the sender until every queued operation has completed.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || req.valid || expected_results.size() != 0);
    endtask

    // Request driver: a transfer is predicted at the edge where it happens.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid           <= 1'b0;
            req.kind            <= KIND_INSERT;
            req.answer_id       <= '0;
            req.question_length <= '0;
            req.keyword_count   <= '0;
            req.entry_handle    <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_list_op(driven_op);
            if (!req.valid || req.ready)
            begin
                if (pending_ops.size() > 0
                    && (calm_phase || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    driven_op            = pending_ops.pop_front();
                    req.valid           <= 1'b1;
                    req.kind            <= driven_op.kind;
                    req.answer_id       <= driven_op.entry.answer_id;
                    req.question_length <= driven_op.entry.question_length;
                    req.keyword_count   <= driven_op.entry.keyword_count;
                    req.entry_handle    <= driven_op.entry.handle;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Result monitor with a randomly stalling receiver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen_result.accepted              = rsp.accepted;
                seen_result.duplicate             = rsp.duplicate;
                seen_result.has_entry             = rsp.has_entry;
                seen_result.entry.answer_id       = rsp.out_answer_id;
                seen_result.entry.question_length = rsp.out_question_length;
                seen_result.entry.keyword_count   = rsp.out_keyword_count;
                seen_result.entry.handle          = rsp.out_handle;
                seen_result.list_size             = rsp.list_size;
                seen_result.last                  = rsp.last;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none expected, got 0x%0h", $time, seen_result);
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    checked_count++;
                    compare_field("accepted", 32'(due_result.accepted),
                                  32'(seen_result.accepted));
                    compare_field("duplicate", 32'(due_result.duplicate),
                                  32'(seen_result.duplicate));
                    compare_field("has_entry", 32'(due_result.has_entry),
                                  32'(seen_result.has_entry));
                    compare_field("out_answer_id", due_result.entry.answer_id,
                                  seen_result.entry.answer_id);
                    compare_field("out_question_length",
                                  32'(due_result.entry.question_length),
                                  32'(seen_result.entry.question_length));
                    compare_field("out_keyword_count",
                                  32'(due_result.entry.keyword_count),
                                  32'(seen_result.entry.keyword_count));
                    compare_field("out_handle", due_result.entry.handle,
                                  seen_result.entry.handle);
                    compare_field("list_size", 32'(due_result.list_size),
                                  32'(seen_result.list_size));
                    compare_field("last", 32'(due_result.last), 32'(seen_result.last));
                end
            end
            rsp.ready <= calm_phase || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus: directed cases, then phases of well-formed fills and random noise.
    initial
    begin
        int          phase;
        int          fill_len;
        int          random_start;
        logic [31:0] aid;
        logic [15:0] qlen;
        logic [7:0]  kw;

        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.kind            = KIND_INSERT;
        req.answer_id       = '0;
        req.question_length = '0;
        req.keyword_count   = '0;
        req.entry_handle    = '0;
        rsp.ready           = 1'b0;
        calm_phase          = 1'b0;
        held_total          = 0;
        queued_count        = 0;
        error_count         = 0;
        checked_count       = 0;
        cycle_count         = 0;
        insert_count        = 0;
        duplicate_count     = 0;
        reject_count        = 0;
        replace_count       = 0;
        dump_count          = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty list: dump, unused code and clear.
        queue_op(KIND_DUMP, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_op(KIND_UNUSED, 32'h1234_5678, 16'h0042, 8'h11, 32'hDEAD_BEEF);
        queue_op(KIND_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // Field extremes, a duplicate id, and equal and tied keys.
        queue_op(KIND_INSERT, 32'h0000_0000, 16'h0000, 8'h00, 32'h0000_0000);
        queue_op(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_op(KIND_INSERT, 32'h0000_0000, 16'h0010, 8'h05, 32'hAAAA_5555);
        queue_op(KIND_INSERT, 32'h0000_0005, 16'd100, 8'd3, 32'h0000_0105);
        queue_op(KIND_INSERT, 32'h0000_0006, 16'd100, 8'd3, 32'h0000_0106);
        queue_op(KIND_INSERT, 32'h0000_0007, 16'd100, 8'd9, 32'h0000_0107);
        queue_op(KIND_INSERT, 32'h0000_0008, 16'd100, 8'd0, 32'h0000_0108);
        queue_op(KIND_INSERT, 32'hFFFF_FFFF, 16'h0001, 8'h01, 32'h5555_AAAA);
        queue_op(KIND_DUMP, 32'h0, 16'h0, 8'h0, 32'h0);
        queue_op(KIND_UNUSED, 32'h0, 16'h0, 8'h0, 32'h0);
        queue_op(KIND_CLEAR, 32'h0, 16'h0, 8'h0, 32'h0);
        queue_op(KIND_DUMP, 32'h0, 16'h0, 8'h0, 32'h0);
        queue_op(KIND_INSERT, 32'h0000_0005, 16'd7, 8'd2, 32'h0000_0205);
        queue_op(KIND_DUMP, 32'h0, 16'h0, 8'h0, 32'h0);
        wait_until_drained();

        random_start = queued_count;
        phase        = 0;
        while (queued_count - random_start < RANDOM_ITEMS)
        begin
            // One phase runs with neither side idling.
            calm_phase = (phase == 2);
            if (phase < 3 || $urandom_range(99) < 70)
            begin
                // Fill: inserts with occasional repeated ids, overflowing the list at times.
                if (phase == 0 || $urandom_range(99) < 80)
                    queue_op(KIND_CLEAR, $urandom(), 16'($urandom()), 8'($urandom()),
                             $urandom());
                fill_len = (phase == 0 || phase == 2) ? 24 : $urandom_range(4, 24);
                used_ids.delete();
                for (int k = 0; k < fill_len; k++)
                begin
                    if (used_ids.size() > 0 && $urandom_range(99) < 15)
                        aid = used_ids[$urandom_range(used_ids.size() - 1)];
                    else
                    begin
                        aid = $urandom();
                        used_ids.push_back(aid);
                    end
                    case ($urandom_range(3))
                        0: qlen = 16'($urandom_range(7));
                        1: qlen = 16'($urandom());
                        2: qlen = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                        default: qlen = 16'($urandom_range(3));
                    endcase
                    kw = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom());
                    queue_op(KIND_INSERT, aid, qlen, kw, $urandom());
                    if ($urandom_range(99) < 8)
                        queue_op(KIND_DUMP, $urandom(), 16'($urandom()), 8'($urandom()),
                                 $urandom());
                end
                queue_op(KIND_DUMP, $urandom(), 16'($urandom()), 8'($urandom()), $urandom());
            end
            else
            begin
                // Noise: any code with random fields.
                repeat ($urandom_range(3, 8))
                begin
                    aid = (used_ids.size() > 0 && $urandom_range(1))
                          ? used_ids[$urandom_range(used_ids.size() - 1)] : $urandom();
                    queue_op(2'($urandom_range(3)), aid, 16'($urandom()), 8'($urandom()),
                             $urandom());
                end
            end
            if (phase % 3 == 1)
                wait_until_drained();
            else
                while (pending_ops.size() > 0)
                    @(negedge clk);
            phase++;
        end
        calm_phase = 1'b0;

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d inserts: %0d duplicates, %0d rank rejections, %0d replacements.",
                 insert_count, duplicate_count, reject_count, replace_count);
        $display("%0d dumps, %0d results checked, %0d mismatches.",
                 dump_count, checked_count, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
